// ----- src/crbu_pkg.sv -----
`timescale 1ns / 1ps

package crbu_pkg;

    localparam int PIXEL_W    = 16;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int COUNT_W    = 16;
    localparam int OUT_ADDR_W = 17;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RECT_LEFT   = 3'd0,
        REG_RECT_TOP    = 3'd1,
        REG_RECT_WIDTH  = 3'd2,
        REG_RECT_HEIGHT = 3'd3,
        REG_DRAW_MODE   = 3'd4,
        REG_FILL_COLOR  = 3'd5
    } t_reg_index;

    // Drawing modes; the unused code consumes elements and draws nothing
    typedef enum logic [1:0] {
        MODE_FILL = 2'd0,
        MODE_COPY = 2'd1,
        MODE_MASK = 2'd2,
        MODE_NONE = 2'd3
    } t_draw_mode;

    // How the back end forms the stored pixel
    typedef enum logic {
        OP_DIRECT = 1'b0,
        OP_BLEND  = 1'b1
    } t_op_kind;

    // Direct: value is the pixel. Blend: value is the mask over fill color.
    typedef struct packed {
        t_op_kind             kind;
        logic [PIXEL_W-1:0]   value;
    } t_pix_op;

    // Expand an 8-bit grey level to an RGB565 mask
    function automatic logic [PIXEL_W-1:0] grey_mask(input logic [7:0] g);
        grey_mask = {g[7:3], g[7:2], g[7:3]};
    endfunction

endpackage

// ----- src/crbu_queue.sv -----
`timescale 1ns / 1ps

module crbu_queue #(
    parameter int DATA_W = 34,
    parameter int DEPTH  = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [DATA_W-1:0]          i_data,
    input  logic                       i_pop,
    output logic                       o_valid,
    output logic [DATA_W-1:0]          o_data,
    output logic [$clog2(DEPTH):0]     o_count
);

    localparam int PTR_W = $clog2(DEPTH);

    logic [DATA_W-1:0] r_data [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [PTR_W:0]    r_count, n_count;

    // Advance pointers and occupancy
    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + PTR_W'(1) : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + PTR_W'(1) : r_rd_ptr;
        n_count  = r_count + (PTR_W+1)'(i_push) - (PTR_W+1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wr_ptr] <= i_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_data[r_rd_ptr];
    assign o_count = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == (PTR_W+1)'(DEPTH)) |-> (!i_push || i_pop))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> !i_pop)
        else $error("queue pop while empty");

endmodule

// ----- src/crbu_front.sv -----
`timescale 1ns / 1ps

module crbu_front
    import crbu_pkg::*;
#(
    parameter int FRAME_WIDTH  = 320,
    parameter int FRAME_HEIGHT = 240,
    parameter int QUEUE_DEPTH  = 4,
    parameter int ADDR_W       = 17
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_W-1:0]              i_cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [PIXEL_W-1:0]            s_tdata,
    input  logic                          i_clearing,
    input  logic [$clog2(QUEUE_DEPTH):0]  i_q_count,
    output logic                          o_push,
    output logic [ADDR_W-1:0]             o_push_addr,
    output t_pix_op                       o_push_op,
    output logic [PIXEL_W-1:0]            o_fill_color
);

    localparam int X_W   = (FRAME_WIDTH  > 1) ? $clog2(FRAME_WIDTH)  : 1;
    localparam int Y_W   = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;
    localparam int SUM_W = $clog2(QUEUE_DEPTH) + 2;

    // Configuration registers
    logic [CFG_W-1:0]   r_rect_left;
    logic [CFG_W-1:0]   r_rect_top;
    logic [CFG_W-1:0]   r_rect_width;
    logic [CFG_W-1:0]   r_rect_height;
    logic [1:0]         r_draw_mode;
    logic [PIXEL_W-1:0] r_fill_color;

    // Position counters
    logic [COUNT_W-1:0] r_col, n_col;
    logic [COUNT_W-1:0] r_row, n_row;

    // Stage 1: accepted element with its position
    logic               r_s1_valid;
    logic [PIXEL_W-1:0] r_s1_src;
    logic [COUNT_W-1:0] r_s1_col;
    logic [COUNT_W-1:0] r_s1_row;

    // Stage 2: clipped coordinates and pixel operation
    logic               r_s2_valid;
    logic [X_W-1:0]     r_s2_x;
    logic [Y_W-1:0]     r_s2_y;
    t_pix_op            r_s2_op;

    logic [16:0] w_width17, w_height17, w_abs_w, w_abs_h;
    logic [16:0] w_left_n, w_top_n;
    logic        w_empty, w_mode_ok, w_accept, w_col_wrap, w_row_wrap;
    logic [17:0] w_x, w_y;
    logic        w_inside;
    t_pix_op     w_op;
    logic [SUM_W-1:0] w_inflight;

    // Normalize the rectangle
    always_comb begin
        w_width17  = {r_rect_width[CFG_W-1], r_rect_width};
        w_height17 = {r_rect_height[CFG_W-1], r_rect_height};
        w_abs_w    = r_rect_width[CFG_W-1]  ? 17'd0 - w_width17  : w_width17;
        w_abs_h    = r_rect_height[CFG_W-1] ? 17'd0 - w_height17 : w_height17;
        w_left_n   = {r_rect_left[CFG_W-1], r_rect_left}
                   + (r_rect_width[CFG_W-1] ? w_width17 : 17'd0);
        w_top_n    = {r_rect_top[CFG_W-1], r_rect_top}
                   + (r_rect_height[CFG_W-1] ? w_height17 : 17'd0);
        w_empty    = (w_abs_w == 17'd0) || (w_abs_h == 17'd0);
        w_mode_ok  = (r_draw_mode == MODE_FILL) || (r_draw_mode == MODE_COPY)
                  || (r_draw_mode == MODE_MASK);
    end

    // Hold input while the store clears or the queue could overflow
    always_comb begin
        w_inflight = SUM_W'(i_q_count) + SUM_W'(r_s1_valid) + SUM_W'(r_s2_valid);
        s_tready   = !i_clearing && (w_inflight < SUM_W'(QUEUE_DEPTH));
        w_accept   = s_tvalid && s_tready;
    end

    // Step the raster counters
    always_comb begin
        w_col_wrap = ({1'b0, r_col} + 17'd1) >= w_abs_w;
        w_row_wrap = ({1'b0, r_row} + 17'd1) >= w_abs_h;
        n_col = r_col;
        n_row = r_row;
        if (w_accept) begin
            if (w_empty) begin
                n_col = '0;
                n_row = '0;
            end else if (w_col_wrap) begin
                n_col = '0;
                n_row = w_row_wrap ? '0 : r_row + COUNT_W'(1);
            end else begin
                n_col = r_col + COUNT_W'(1);
            end
        end
        if (i_cfg_we && (i_cfg_index <= REG_FILL_COLOR)) begin
            n_col = '0;
            n_row = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rect_left   <= '0;
            r_rect_top    <= '0;
            r_rect_width  <= '0;
            r_rect_height <= '0;
            r_draw_mode   <= MODE_FILL;
            r_fill_color  <= '0;
            r_col         <= '0;
            r_row         <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_RECT_LEFT:   r_rect_left   <= i_cfg_wdata;
                    REG_RECT_TOP:    r_rect_top    <= i_cfg_wdata;
                    REG_RECT_WIDTH:  r_rect_width  <= i_cfg_wdata;
                    REG_RECT_HEIGHT: r_rect_height <= i_cfg_wdata;
                    REG_DRAW_MODE:   r_draw_mode   <= i_cfg_wdata[1:0];
                    REG_FILL_COLOR:  r_fill_color  <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // Stage 1: drop elements that can never draw
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_accept && !w_empty && w_mode_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_src <= s_tdata;
            r_s1_col <= r_col;
            r_s1_row <= r_row;
        end
    end

    // Clip against the frame and pick the pixel operation
    always_comb begin
        w_x = {w_left_n[16], w_left_n} + {2'b00, r_s1_col};
        w_y = {w_top_n[16], w_top_n} + {2'b00, r_s1_row};
        w_inside = !w_x[17] && (w_x[16:0] < 17'(FRAME_WIDTH))
                && !w_y[17] && (w_y[16:0] < 17'(FRAME_HEIGHT));
        case (r_draw_mode)
            MODE_COPY: w_op = '{kind: OP_DIRECT, value: r_s1_src};
            MODE_MASK: w_op = '{kind: OP_BLEND, value: grey_mask(r_s1_src[7:0])};
            default:   w_op = '{kind: OP_DIRECT, value: r_fill_color};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid && w_inside;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_x  <= w_x[X_W-1:0];
        r_s2_y  <= w_y[Y_W-1:0];
        r_s2_op <= w_op;
    end

    // Stage 2: form the store address and hand over to the queue
    assign o_push       = r_s2_valid;
    assign o_push_addr  = ADDR_W'(r_s2_y * FRAME_WIDTH) + ADDR_W'(r_s2_x);
    assign o_push_op    = r_s2_op;
    assign o_fill_color = r_fill_color;

    a_ready_low_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_clearing |-> !s_tready)
        else $error("input taken during store clear");

    a_no_push_after_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && !s_tvalid && !r_s1_valid) |=> !r_s2_valid)
        else $error("push without an accepted element");

endmodule

// ----- src/crbu_back.sv -----
`timescale 1ns / 1ps

module crbu_back
    import crbu_pkg::*;
#(
    parameter int FRAME_WIDTH  = 320,
    parameter int FRAME_HEIGHT = 240,
    parameter int ADDR_W       = 17
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [PIXEL_W-1:0]     i_fill_color,
    input  logic                   i_q_valid,
    input  logic [ADDR_W-1:0]      i_q_addr,
    input  t_pix_op                i_q_op,
    output logic                   o_q_pop,
    output logic                   o_clearing,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [39:0]            m_tdata
);

    localparam int STORE_DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int EXT_W       = (ADDR_W > OUT_ADDR_W) ? ADDR_W : OUT_ADDR_W;

    logic [PIXEL_W-1:0] r_mem [STORE_DEPTH];
    logic [PIXEL_W-1:0] r_mem_q;

    // Clearing pass
    logic               r_clearing;
    logic [ADDR_W-1:0]  r_clr_addr;

    // Read stage
    logic               r_a_valid;
    logic [ADDR_W-1:0]  r_a_addr;
    t_pix_op            r_a_op;
    logic               r_a_fwd;
    logic [PIXEL_W-1:0] r_a_fwd_data;

    // Output register
    logic               r_b_valid;
    logic [ADDR_W-1:0]  r_b_addr;
    logic [PIXEL_W-1:0] r_b_pix;

    logic               w_b_ready, w_a_adv, w_a_load;
    logic [PIXEL_W-1:0] w_stored, w_pix;
    logic               w_wr_en;
    logic [ADDR_W-1:0]  w_wr_addr;
    logic [PIXEL_W-1:0] w_wr_data;
    logic [EXT_W-1:0]   w_out_addr;

    // Advance the read stage when the output register frees up
    always_comb begin
        w_b_ready = !r_b_valid || m_tready;
        w_a_adv   = r_a_valid && w_b_ready;
        w_a_load  = i_q_valid && !r_clearing && (!r_a_valid || w_a_adv);
    end

    // Blend against the stored pixel, or the one written as this entry was loaded
    always_comb begin
        w_stored = r_a_fwd ? r_a_fwd_data : r_mem_q;
        case (r_a_op.kind)
            OP_BLEND: w_pix = (w_stored & ~r_a_op.value) | (i_fill_color & r_a_op.value);
            default:  w_pix = r_a_op.value;
        endcase
    end

    // Share the write port between clearing and drawing
    always_comb begin
        w_wr_en   = r_clearing || w_a_adv;
        w_wr_addr = r_clearing ? r_clr_addr : r_a_addr;
        w_wr_data = r_clearing ? '0 : w_pix;
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_a_load) begin
            r_mem_q <= r_mem[i_q_addr];
        end
    end

    // Sweep the store once after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
            if (r_clr_addr == ADDR_W'(STORE_DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // Read stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_a_load) begin
            r_a_valid <= 1'b1;
        end else if (w_a_adv) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_load) begin
            r_a_addr     <= i_q_addr;
            r_a_op       <= i_q_op;
            r_a_fwd      <= w_a_adv && (r_a_addr == i_q_addr);
            r_a_fwd_data <= w_pix;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_a_adv) begin
            r_b_valid <= 1'b1;
        end else if (m_tready) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_adv) begin
            r_b_addr <= r_a_addr;
            r_b_pix  <= w_pix;
        end
    end

    assign w_out_addr = EXT_W'(r_b_addr);
    assign o_q_pop    = w_a_load;
    assign o_clearing = r_clearing;
    assign m_tvalid   = r_b_valid;
    assign m_tdata    = {7'd0, r_b_pix, w_out_addr[OUT_ADDR_W-1:0]};

    a_no_pop_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !o_q_pop)
        else $error("queue popped during store clear");

    a_read_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && !w_b_ready) |=> (r_a_valid && $stable(r_a_addr)))
        else $error("read stage lost its transaction under stall");

    a_no_result_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !w_a_adv)
        else $error("pixel drawn during store clear");

endmodule

// ----- src/clipped_rectangle_blitter_unit.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Handshake          Payload (low bit first)
// s         in         s_tvalid/s_tready  s_tdata[15:0] source_value
// m         out        m_tvalid/m_tready  m_tdata[16:0] write_address, [32:17] write_pixel
// cfg       in         i_cfg_we           i_cfg_index, i_cfg_wdata
//
// One source element per clock while s_tready is high; a pixel write passes classify
// stages one and two, the queue, the store read and the output register to reach m.
// After reset the frame store is swept to zero with s_tready low; configuration
// writes are taken as ever. A four-entry queue parts classification from the store;
// s_tready drops when the queue and the classify stages together could overfill it.

module clipped_rectangle_blitter_unit
    import crbu_pkg::*;
#(
    parameter int FRAME_WIDTH  = 320,
    parameter int FRAME_HEIGHT = 240
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,   // [15:0] source_value
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [39:0]           m_tdata    // [16:0] write_address, [32:17] write_pixel
);

    localparam int QUEUE_DEPTH = 4;
    localparam int STORE_DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int OP_W        = $bits(t_pix_op);
    localparam int Q_DATA_W    = ADDR_W + OP_W;

    logic                          w_push;
    logic [ADDR_W-1:0]             w_push_addr;
    t_pix_op                       w_push_op;
    logic [PIXEL_W-1:0]            w_fill_color;
    logic                          w_clearing;
    logic [$clog2(QUEUE_DEPTH):0]  w_q_count;
    logic                          w_q_valid;
    logic                          w_q_pop;
    logic [Q_DATA_W-1:0]           w_q_data;
    logic [ADDR_W-1:0]             w_q_addr;
    t_pix_op                       w_q_op;

    crbu_front #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT),
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .ADDR_W       (ADDR_W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .i_clearing   (w_clearing),
        .i_q_count    (w_q_count),
        .o_push       (w_push),
        .o_push_addr  (w_push_addr),
        .o_push_op    (w_push_op),
        .o_fill_color (w_fill_color)
    );

    crbu_queue #(
        .DATA_W (Q_DATA_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_push_addr, w_push_op}),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_data),
        .o_count (w_q_count)
    );

    assign w_q_addr = w_q_data[Q_DATA_W-1:OP_W];
    assign w_q_op   = t_pix_op'(w_q_data[OP_W-1:0]);

    crbu_back #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT),
        .ADDR_W       (ADDR_W)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fill_color (w_fill_color),
        .i_q_valid    (w_q_valid),
        .i_q_addr     (w_q_addr),
        .i_q_op       (w_q_op),
        .o_q_pop      (w_q_pop),
        .o_clearing   (w_clearing),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

endmodule

// ----- dv/blit_write_checker.sv -----
`timescale 1ns / 1ps

module blit_write_checker
    import crbu_pkg::*;
#(
    parameter int FRAME_W = 320,
    parameter int FRAME_H = 240
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [15:0]          i_s_tdata,   // [15:0] source_value
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [39:0]          i_m_tdata,   // [16:0] write_address, [32:17] write_pixel
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_writes_checked
);

    typedef struct packed {
        logic [OUT_ADDR_W-1:0] addr;
        logic [PIXEL_W-1:0]    pix;
    } t_pix_write;

    // Shadow copy of the frame store and the drawing state
    logic [PIXEL_W-1:0] pixels [FRAME_W*FRAME_H];
    logic [CFG_W-1:0]   cfg_left, cfg_top, cfg_width, cfg_height, cfg_color;
    logic [1:0]         cfg_mode;
    logic [COUNT_W-1:0] col_pos, row_pos;
    t_pix_write         write_q [$];

    // Apply one register write; unknown indexes leave everything alone
    task automatic apply_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_W-1:0] value);
        case (index)
            REG_RECT_LEFT:   cfg_left   = value;
            REG_RECT_TOP:    cfg_top    = value;
            REG_RECT_WIDTH:  cfg_width  = value;
            REG_RECT_HEIGHT: cfg_height = value;
            REG_DRAW_MODE:   cfg_mode   = value[1:0];
            REG_FILL_COLOR:  cfg_color  = value;
            default:         return;
        endcase
        col_pos = '0;
        row_pos = '0;
    endtask

    // Place one source element, queue its pixel write if it lands in the frame
    task automatic draw_element(input logic [15:0] src);
        int left, top, w, h, x, y;
        logic [OUT_ADDR_W-1:0] addr;
        logic [PIXEL_W-1:0]    mask, pix;
        left = $signed(cfg_left);
        top  = $signed(cfg_top);
        w    = $signed(cfg_width);
        h    = $signed(cfg_height);
        if (w < 0) begin
            left += w;
            w = -w;
        end
        if (h < 0) begin
            top += h;
            h = -h;
        end
        if (w == 0 || h == 0) begin
            col_pos = '0;
            row_pos = '0;
            return;
        end
        x = left + int'(col_pos);
        y = top + int'(row_pos);
        if (cfg_mode != MODE_NONE && x >= 0 && x < FRAME_W && y >= 0 && y < FRAME_H) begin
            addr = OUT_ADDR_W'(y * FRAME_W + x);
            case (cfg_mode)
                MODE_FILL: pix = cfg_color;
                MODE_COPY: pix = src;
                default: begin
                    // grey level to RGB565 mask, then blend over the stored pixel
                    mask = {src[7:3], src[7:2], src[7:3]};
                    pix  = (pixels[y * FRAME_W + x] & ~mask) | (cfg_color & mask);
                end
            endcase
            pixels[y * FRAME_W + x] = pix;
            write_q.push_back('{addr: addr, pix: pix});
        end
        // Advance raster position, wrapping after the last element
        if (int'(col_pos) + 1 >= w) begin
            col_pos = '0;
            if (int'(row_pos) + 1 >= h) row_pos = '0;
            else row_pos = row_pos + 1'b1;
        end else begin
            col_pos = col_pos + 1'b1;
        end
    endtask

    // Compare output transactions first, then take config and source transactions
    always @(posedge i_clk) begin
        t_pix_write seen, want;
        if (!i_rst_n) begin
            foreach (pixels[i]) pixels[i] = '0;
            cfg_left   = '0;
            cfg_top    = '0;
            cfg_width  = '0;
            cfg_height = '0;
            cfg_mode   = '0;
            cfg_color  = '0;
            col_pos    = '0;
            row_pos    = '0;
            write_q.delete();
            o_fail_count     = 0;
            o_writes_checked = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                seen = '{addr: i_m_tdata[OUT_ADDR_W-1:0],
                         pix:  i_m_tdata[OUT_ADDR_W +: PIXEL_W]};
                if (write_q.size() == 0) begin
                    $error("unexpected write transaction: write_address %0d write_pixel %h",
                           seen.addr, seen.pix);
                    o_fail_count++;
                end else begin
                    want = write_q.pop_front();
                    if (seen.addr !== want.addr) begin
                        $error("write_address mismatch: expected %0d, actual %0d",
                               want.addr, seen.addr);
                        o_fail_count++;
                    end
                    if (seen.pix !== want.pix) begin
                        $error("write_pixel mismatch: expected %h, actual %h",
                               want.pix, seen.pix);
                        o_fail_count++;
                    end
                    o_writes_checked++;
                end
            end
            if (i_cfg_we) apply_register(i_cfg_index, i_cfg_wdata);
            if (i_s_tvalid && i_s_tready) draw_element(i_s_tdata);
        end
        o_pending = write_q.size();
    end

endmodule

// ----- dv/tb_clipped_rectangle_blitter_unit.sv -----
`timescale 1ns / 1ps

module tb_clipped_rectangle_blitter_unit
    import crbu_pkg::*;
();

    localparam int FRAME_W       = 320;
    localparam int FRAME_H       = 240;
    localparam int ITEM_TARGET   = 550;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 400000;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [15:0]          s_tdata;   // [15:0] source_value
    logic                 m_tvalid;
    logic                 m_tready;
    logic [39:0]          m_tdata;   // [16:0] write_address, [32:17] write_pixel

    int fail_count, pending, writes_checked;
    int elements_sent = 0;
    int rect_settings = 0;
    int cycle_count   = 0;
    bit hold_go       = 1'b0;
    bit calm          = 1'b0;

    clipped_rectangle_blitter_unit #(
        .FRAME_WIDTH  (FRAME_W),
        .FRAME_HEIGHT (FRAME_H)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    blit_write_checker #(
        .FRAME_W (FRAME_W),
        .FRAME_H (FRAME_H)
    ) u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_s_tvalid       (s_tvalid),
        .i_s_tready       (s_tready),
        .i_s_tdata        (s_tdata),
        .i_m_tvalid       (m_tvalid),
        .i_m_tready       (m_tready),
        .i_m_tdata        (m_tdata),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_writes_checked (writes_checked)
    );

    always #6 i_clk = ~i_clk;

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Drive one register write; caller drops the write enable after the last one
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_wdata <= value;
        @(negedge i_clk);
    endtask

    // Load the full rectangle setup
    task automatic program_rect(input int left, input int top, input int w, input int h,
                                input logic [15:0] mode_word, input logic [15:0] color);
        write_reg(REG_RECT_LEFT,   16'(left));
        write_reg(REG_RECT_TOP,    16'(top));
        write_reg(REG_RECT_WIDTH,  16'(w));
        write_reg(REG_RECT_HEIGHT, 16'(h));
        write_reg(REG_DRAW_MODE,   mode_word);
        write_reg(REG_FILL_COLOR,  color);
        i_cfg_we <= 1'b0;
        rect_settings++;
    endtask

    // Offer one source element and hold it until the transaction completes
    task automatic send_element(input logic [15:0] value);
        while (!calm && $urandom_range(0, 99) < 6) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        elements_sent++;
        @(negedge i_clk);
    endtask

    // Drop valid, drain expected writes, then let the pipeline empty
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [15:0] pick_source();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return {8'($urandom), 8'hFF};
            default: return 16'($urandom);
        endcase
    endfunction

    // Output side: random back-pressure, one long hold-off on request
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        m_tready  = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_go) begin
                hold_go   = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            @(negedge i_clk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= calm || ($urandom_range(0, 99) >= 6);
            end
        end
    end

    initial begin : stimulus
        int left, top, w, h, count, split, kind;
        logic [1:0] mode;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_wdata = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Empty rectangle straight out of reset
        send_element(16'hFFFF);

        // Fill across the bottom-right corner, then wrap past the last element
        settle();
        program_rect(318, 238, 3, 2, {14'h0, MODE_FILL}, 16'hF81F);
        for (int i = 0; i < 8; i++) send_element(16'(i));

        // Copy with negative sizes, mostly off the top-left edge
        settle();
        program_rect(1, 1, -3, -2, {14'h0, MODE_COPY}, 16'h0000);
        send_element(16'hFFFF);
        send_element(16'h0000);
        send_element(16'hA5A5);
        send_element(16'h5A5A);
        send_element(16'h8001);
        send_element(16'h7FFE);

        // Masked fill over the filled corner; unknown indexes must not restart the raster
        settle();
        program_rect(318, 238, 3, 2, {14'h0, MODE_MASK}, 16'h07E0);
        send_element(16'hFF00);
        send_element(16'h00FF);
        send_element(16'h005A);
        settle();
        write_reg(REG_SPARE_A, 16'hFFFF);
        write_reg(REG_SPARE_B, 16'h5555);
        i_cfg_we <= 1'b0;
        send_element(16'h0080);
        send_element(16'h0007);
        send_element(16'hFFFF);

        // Unused mode draws nothing
        settle();
        program_rect(0, 0, 4, 1, {14'h3FFF, MODE_NONE}, 16'hFFFF);
        send_element(16'h1234);
        send_element(16'hFFFF);

        // Register extremes
        settle();
        program_rect(-32768, -32768, -32768, -32768, {14'h0, MODE_FILL}, 16'h0000);
        send_element(16'h0000);
        settle();
        program_rect(32767, 32767, 32767, 32767, {14'h0, MODE_COPY}, 16'hFFFF);
        send_element(16'hFFFF);

        // Long output hold-off while the source keeps streaming
        settle();
        program_rect(100, 100, 16, 10, {14'h0, MODE_COPY}, 16'h0000);
        hold_go = 1'b1;
        for (int i = 0; i < 160; i++) send_element(pick_source());

        // Stretch with no idling on either side
        settle();
        calm = 1'b1;
        program_rect(2, 3, 12, 10, {14'h0, MODE_MASK}, 16'($urandom));
        for (int i = 0; i < 120; i++) send_element(pick_source());
        settle();
        calm = 1'b0;

        // Random rectangles, mostly near the frame corners so they clip and overlap
        while (elements_sent < ITEM_TARGET) begin
            settle();
            mode = ($urandom_range(0, 9) == 0) ? MODE_NONE : 2'($urandom_range(0, 2));
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                if ($urandom_range(0, 1)) begin
                    left = int'($urandom_range(0, 32)) - 8;
                    top  = int'($urandom_range(0, 32)) - 8;
                end else begin
                    left = $urandom_range(296, 327);
                    top  = $urandom_range(216, 247);
                end
                w = $urandom_range(1, 12);
                h = $urandom_range(1, 8);
                count = w * h;
                if ($urandom_range(0, 3) == 0) w = -w;
                if ($urandom_range(0, 3) == 0) h = -h;
                if ($urandom_range(0, 3) == 0) count += $urandom_range(1, 6);
                else if ($urandom_range(0, 5) == 0) count = $urandom_range(1, count);
            end else if (kind < 9) begin
                left  = int'($urandom_range(0, 65535)) - 32768;
                top   = int'($urandom_range(0, 65535)) - 32768;
                w     = int'($urandom_range(0, 65535)) - 32768;
                h     = int'($urandom_range(0, 65535)) - 32768;
                count = $urandom_range(1, 8);
            end else begin
                left  = int'($urandom_range(0, 40)) - 20;
                top   = int'($urandom_range(0, 40)) - 20;
                w     = $urandom_range(0, 1) ? 0 : int'($urandom_range(0, 65535)) - 32768;
                h     = (w == 0) ? int'($urandom_range(0, 65535)) - 32768 : 0;
                count = $urandom_range(1, 4);
            end
            program_rect(left, top, w, h, {14'($urandom), mode}, 16'($urandom));
            split = (count > 2 && $urandom_range(0, 6) == 0) ? count / 2 : 0;
            for (int i = 0; i < count; i++) begin
                // Mid-raster color change restarts the raster
                if (split != 0 && i == split) begin
                    settle();
                    write_reg(REG_FILL_COLOR, 16'($urandom));
                    i_cfg_we <= 1'b0;
                end
                send_element(pick_source());
            end
        end

        settle();
        $display("Streamed %0d source elements through %0d rectangle setups",
                 elements_sent, rect_settings);
        $display("Checked %0d pixel writes, including clipped, masked and wrapped rasters",
                 writes_checked);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
